/* src/ils_pkg.sv */
package ils_pkg;

    // default list capacity
    localparam int CAPACITY_DEF = 64;

    // field widths
    localparam int ACT_W       = 3;
    localparam int POS_W       = 10;
    localparam int VAL_W       = 32;
    localparam int STAT_W      = 2;
    localparam int ENTRY_CNT_W = 7;

    // compare width: holds any position and any count up to 1024
    localparam int CMP_W = 11;

    // action codes
    localparam logic [ACT_W-1:0] ACT_READ      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INS_BACK  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_INS_POS   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DELETE    = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [STAT_W-1:0]       status;
        logic [ENTRY_CNT_W-1:0]  entry_count;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_NEW_WR,
        ST_FINISH
    } state_t;

endpackage

/* src/ils_core.sv */
module ils_core
    import ils_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic ready,
    input  logic res_ready,
    output logic done,
    output rsp_t rsp
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // entry storage
    logic [VAL_W-1:0] mem [CAPACITY];
    logic [VAL_W-1:0] rdata_reg;
    logic [AW-1:0]    mem_raddr;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic             mem_we;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [VAL_W-1:0]  value_reg, value_next;
    logic              up_reg, up_next;
    logic [VAL_W-1:0]  rd_reg, rd_next;
    logic [STAT_W-1:0] st_reg, st_next;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] ins_pos;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] idx_dec;
    logic             is_insert;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        value_reg <= value_next;
        up_reg    <= up_next;
        rd_reg    <= rd_next;
        st_reg    <= st_next;
    end

    // shared operands
    assign pos_ext = CMP_W'(req.position);
    assign cnt_ext = CMP_W'(count_reg);
    assign idx_inc = idx_reg + CNT_W'(1);
    assign idx_dec = idx_reg - CNT_W'(1);

    always_comb
    begin
        is_insert = 1'b1;
        case (req.action)
            ACT_INS_FRONT: ins_pos = '0;
            ACT_INS_BACK:  ins_pos = cnt_ext;
            ACT_INS_POS:   ins_pos = pos_ext;
            default:
            begin
                ins_pos   = pos_ext;
                is_insert = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        value_next = value_reg;
        up_next    = up_reg;
        rd_next    = rd_reg;
        st_next    = st_reg;
        mem_raddr  = idx_reg[AW-1:0];
        mem_waddr  = idx_reg[AW-1:0];
        mem_wdata  = rdata_reg;
        mem_we     = 1'b0;
        done       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    value_next = req.value;
                    rd_next    = '0;
                    st_next    = STAT_DONE;
                    state_next = ST_FINISH;
                    if (req.action == ACT_READ)
                    begin
                        if (pos_ext < cnt_ext)
                        begin
                            mem_raddr  = req.position[AW-1:0];
                            state_next = ST_RD_WAIT;
                        end
                        else
                        begin
                            rd_next = '1;
                            st_next = STAT_RANGE;
                        end
                    end
                    else if (is_insert)
                    begin
                        if (ins_pos > cnt_ext)
                        begin
                            st_next = STAT_RANGE;
                        end
                        else if (count_reg == CNT_W'(CAPACITY))
                        begin
                            st_next = STAT_FULL;
                        end
                        else
                        begin
                            // move entries up from the tail down to the slot
                            up_next  = 1'b1;
                            pos_next = ins_pos[CNT_W-1:0];
                            idx_next = count_reg;
                            if (ins_pos == cnt_ext)
                            begin
                                state_next = ST_NEW_WR;
                            end
                            else
                            begin
                                state_next = ST_SHIFT_RD;
                            end
                        end
                    end
                    else if (req.action == ACT_DELETE)
                    begin
                        if (pos_ext >= cnt_ext)
                        begin
                            st_next = STAT_RANGE;
                        end
                        else
                        begin
                            // move later entries down to close the gap
                            up_next  = 1'b0;
                            pos_next = pos_ext[CNT_W-1:0];
                            idx_next = pos_ext[CNT_W-1:0];
                            if ((pos_ext + CMP_W'(1)) < cnt_ext)
                            begin
                                state_next = ST_SHIFT_RD;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                    end
                    else
                    begin
                        st_next = STAT_RANGE;
                    end
                end
            end

            ST_RD_WAIT:
            begin
                rd_next    = rdata_reg;
                state_next = ST_FINISH;
            end

            ST_SHIFT_RD:
            begin
                mem_raddr  = up_reg ? idx_dec[AW-1:0] : idx_inc[AW-1:0];
                state_next = ST_SHIFT_WR;
            end

            ST_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                mem_wdata = rdata_reg;
                if (up_reg)
                begin
                    idx_next = idx_dec;
                    if (idx_dec == pos_reg)
                    begin
                        state_next = ST_NEW_WR;
                    end
                    else
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                end
                else
                begin
                    idx_next = idx_inc;
                    if ((CMP_W'(idx_inc) + CMP_W'(1)) < cnt_ext)
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_NEW_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg[AW-1:0];
                mem_wdata  = value_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (res_ready)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ready = (state_reg == ST_IDLE);

    // result fields
    logic [CMP_W-1:0] count_wide;
    assign count_wide      = CMP_W'(count_reg);
    assign rsp.read_value  = rd_reg;
    assign rsp.status      = st_reg;
    assign rsp.entry_count = count_wide[ENTRY_CNT_W-1:0];

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CNT_W'(1) ||
             count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_FINISH) |-> !mem_we)
        else $error("memory write outside a shift or store step");

    a_count_frozen_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |=> (count_reg == $past(count_reg)))
        else $error("count changed while a result waits");

endmodule

/* src/indexed_list_store.sv */
// Indexed list store: an ordered list of up to CAPACITY signed 32-bit
// entries with read, insert front, insert back, insert at position and
// delete at position requests.
// Channels: req (req_valid/req_ready/req) carries one request per transfer,
// rsp (rsp_valid/rsp_ready/rsp) returns exactly one result per request,
// in request order.
// Steps from request transfer to rsp_valid, for n entries held:
//   rejected request or unknown action: ST_IDLE, then ST_FINISH
//   read: ST_RD_WAIT takes the registered memory data, then ST_FINISH
//   insert at position p: n - p shift moves, ST_NEW_WR, then ST_FINISH
//   delete at position p: n - 1 - p shift moves, then ST_FINISH
// Each moved entry takes an ST_SHIFT_RD and an ST_SHIFT_WR step on the
// entry memory; one request is in the sequencer at a time, and the next is
// taken once the previous result has moved into the output register.
// Reset empties the list (count zero); memory contents are not cleared.
// When rsp_ready is low the result waits in the output register, one
// further request can finish into the sequencer, and req_ready then stays
// low until the output register drains.
module indexed_list_store
    import ils_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic rsp_valid_reg;
    rsp_t rsp_reg;
    logic core_ready;
    logic core_done;
    logic res_ready;
    rsp_t core_rsp;

    // sequencer with entry memory
    ils_core #(
        .CAPACITY (CAPACITY)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req_valid && core_ready),
        .req       (req),
        .ready     (core_ready),
        .res_ready (res_ready),
        .done      (core_done),
        .rsp       (core_rsp)
    );

    assign req_ready = core_ready;
    assign res_ready = !rsp_valid_reg || rsp_ready;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (core_done)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_done)
        begin
            rsp_reg <= core_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
